### sv/hrp_pkg.sv
package hrp_pkg;

  localparam int unsigned VersionBits = 8;
  localparam int unsigned ByteW       = 8;

  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChH     = 8'h48;
  localparam logic [ByteW-1:0] ChT     = 8'h54;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam int unsigned      Radix   = 10;

  localparam logic [VersionBits-1:0] VersionMax = {VersionBits{1'b1}};

  typedef enum logic [4:0] {
    PhMethodStart = 5'd0,
    PhMethod      = 5'd1,
    PhUri         = 5'd2,
    PhVerH        = 5'd3,
    PhVerT1       = 5'd4,
    PhVerT2       = 5'd5,
    PhVerP        = 5'd6,
    PhVerSlash    = 5'd7,
    PhMajorStart  = 5'd8,
    PhMajor       = 5'd9,
    PhMinorStart  = 5'd10,
    PhMinor       = 5'd11,
    PhNl1         = 5'd12,
    PhLineStart   = 5'd13,
    PhLws         = 5'd14,
    PhName        = 5'd15,
    PhSpace       = 5'd16,
    PhValue       = 5'd17,
    PhNl2         = 5'd18,
    PhNl3         = 5'd19
  } phase_e;

  typedef enum logic [1:0] {
    StPending = 2'd0,
    StDone    = 2'd1,
    StBad     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RoleNone    = 3'd0,
    RoleMethod  = 3'd1,
    RoleUri     = 3'd2,
    RoleNewName = 3'd3,
    RoleName    = 3'd4,
    RoleValue   = 3'd5
  } role_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    role_e            byte_role;
    logic [ByteW-1:0] byte_echo;
    logic [ByteW-1:0] major_version;
    logic [ByteW-1:0] minor_version;
  } out_item_t;

  function automatic logic is_print(input logic [ByteW-1:0] c);
    return (c >= 8'h21) && (c <= 8'h7E);
  endfunction

  function automatic logic is_ctl(input logic [ByteW-1:0] c);
    return (c <= 8'h1F) || (c == 8'h7F);
  endfunction

  function automatic logic is_sep(input logic [ByteW-1:0] c);
    logic r;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
      8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
      8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default:                     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_tok(input logic [ByteW-1:0] c);
    return is_print(c) && !is_sep(c);
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // acc*10 + digit, saturating; 4 extra bits hold the product without wrap
  function automatic logic [VersionBits-1:0] ver_add(input logic [VersionBits-1:0] acc,
                                                     input logic [ByteW-1:0] c);
    logic [VersionBits+3:0] prod;
    logic [VersionBits+3:0] sum;
    logic [ByteW-1:0]       dig;
    dig  = c - ChZero;
    prod = (VersionBits+4)'(acc) * (VersionBits+4)'(Radix);
    sum  = prod + (VersionBits+4)'(dig[3:0]);
    return (sum > (VersionBits+4)'(VersionMax)) ? VersionMax : sum[VersionBits-1:0];
  endfunction

endpackage

### sv/hrp_core.sv
module hrp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  hrp_pkg::in_item_t item_i,
  output hrp_pkg::out_item_t result_o
);
  import hrp_pkg::*;

  phase_e                 phase_q, phase_cur, phase_nx;
  logic                   seen_q, seen_cur, seen_d;
  logic [VersionBits-1:0] major_q, major_d;
  logic [VersionBits-1:0] minor_q, minor_d;
  logic                   bad;
  status_e                status;
  role_e                  role;
  logic [ByteW-1:0]       c;

  assign c = item_i.data_byte;

  always_comb begin
    // restart takes effect before the byte, even if the byte is malformed
    phase_cur = item_i.restart ? PhMethodStart : phase_q;
    seen_cur  = item_i.restart ? 1'b0 : seen_q;
    phase_nx  = phase_cur;
    seen_d    = seen_cur;
    major_d   = major_q;
    minor_d   = minor_q;
    bad       = 1'b0;
    status    = StPending;
    role      = RoleNone;
    unique case (phase_cur)
      PhMethodStart: begin
        if (is_tok(c)) begin
          phase_nx = PhMethod;
          role     = RoleMethod;
        end else bad = 1'b1;
      end
      PhMethod: begin
        if (c == ChSpace) phase_nx = PhUri;
        else if (is_tok(c)) role = RoleMethod;
        else bad = 1'b1;
      end
      PhUri: begin
        if (c == ChSpace) phase_nx = PhVerH;
        else if (is_ctl(c)) bad = 1'b1;
        else role = RoleUri;
      end
      PhVerH: begin
        if (c == ChH) phase_nx = PhVerT1;
        else bad = 1'b1;
      end
      PhVerT1: begin
        if (c == ChT) phase_nx = PhVerT2;
        else bad = 1'b1;
      end
      PhVerT2: begin
        if (c == ChT) phase_nx = PhVerP;
        else bad = 1'b1;
      end
      PhVerP: begin
        if (c == ChP) phase_nx = PhVerSlash;
        else bad = 1'b1;
      end
      PhVerSlash: begin
        if (c == ChSlash) begin
          major_d  = '0;
          minor_d  = '0;
          phase_nx = PhMajorStart;
        end else bad = 1'b1;
      end
      PhMajorStart: begin
        if (is_digit(c)) begin
          major_d  = ver_add(major_q, c);
          phase_nx = PhMajor;
        end else bad = 1'b1;
      end
      PhMajor: begin
        if (c == ChDot) phase_nx = PhMinorStart;
        else if (is_digit(c)) major_d = ver_add(major_q, c);
        else bad = 1'b1;
      end
      PhMinorStart: begin
        if (is_digit(c)) begin
          minor_d  = ver_add(minor_q, c);
          phase_nx = PhMinor;
        end else bad = 1'b1;
      end
      PhMinor: begin
        if (c == ChCr) phase_nx = PhNl1;
        else if (is_digit(c)) minor_d = ver_add(minor_q, c);
        else bad = 1'b1;
      end
      PhNl1: begin
        if (c == ChLf) phase_nx = PhLineStart;
        else bad = 1'b1;
      end
      PhLineStart: begin
        if (c == ChCr) phase_nx = PhNl3;
        else if (seen_cur && (c == ChSpace || c == ChTab)) phase_nx = PhLws;
        else if (is_tok(c)) begin
          seen_d   = 1'b1;
          role     = RoleNewName;
          phase_nx = PhName;
        end else bad = 1'b1;
      end
      PhLws: begin
        if (c == ChCr) phase_nx = PhNl2;
        else if (c == ChSpace || c == ChTab) phase_nx = PhLws;
        else if (is_ctl(c)) bad = 1'b1;
        else begin
          phase_nx = PhValue;
          role     = RoleValue;
        end
      end
      PhName: begin
        if (c == ChColon) phase_nx = PhSpace;
        else if (is_tok(c)) role = RoleName;
        else bad = 1'b1;
      end
      PhSpace: begin
        if (c == ChSpace) phase_nx = PhValue;
        else bad = 1'b1;
      end
      PhValue: begin
        if (c == ChCr) phase_nx = PhNl2;
        else if (is_ctl(c)) bad = 1'b1;
        else role = RoleValue;
      end
      PhNl2: begin
        if (c == ChLf) phase_nx = PhLineStart;
        else bad = 1'b1;
      end
      PhNl3: begin
        if (c == ChLf) status = StDone;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      status   = StBad;
      role     = RoleNone;
      phase_nx = phase_cur;
      seen_d   = seen_cur;
      major_d  = major_q;
      minor_d  = minor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMethodStart;
      seen_q  <= 1'b0;
      major_q <= '0;
      minor_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_nx;
      seen_q  <= seen_d;
      major_q <= major_d;
      minor_q <= minor_d;
    end
  end

  assign result_o.status        = status;
  assign result_o.byte_role     = role;
  assign result_o.byte_echo     = c;
  assign result_o.major_version = ByteW'(major_d);
  assign result_o.minor_version = ByteW'(minor_d);

  a_bad_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && bad && !item_i.restart |=> phase_q == $past(phase_q))
    else $error("malformed byte moved the parse phase");

  a_done_stays_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && status == StDone |=> phase_q == PhNl3)
    else $error("complete status left the final phase");

  a_role_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && role != RoleNone |-> status == StPending)
    else $error("byte role given on a non-pending byte");

  a_seen_before_lws: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhLws |-> seen_q)
    else $error("continuation phase without a header");

endmodule

### sv/http_request_head_parser.sv
// A byte accepted from the input is held in the input register; the grammar
// step runs into the result register, written once the output has room.
// Throughput: one byte per cycle while the output is not stalled; the grammar
// step between the two registers sets the pace. Reset (rst_ni low,
// asynchronous) empties both registers and puts the parser at method start
// with header-seen and versions cleared.
module http_request_head_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hrp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hrp_pkg::out_item_t out_item_o
);
  import hrp_pkg::*;

  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  result;
  logic       out_free;
  logic       adv;
  logic       in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  hrp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) s1_valid_q <= 1'b1;
      else if (adv) s1_valid_q <= 1'b0;
      if (adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_item_q <= in_item_i;
    if (adv) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("pending input transaction lost");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !adv |=> out_valid_q && $stable(out_item_q))
    else $error("stalled result changed");

  a_adv_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

endmodule
